### src/mse_pkg.sv
// ----------------------------------------------------------------------------
// mse_pkg
// Shared widths, fixed-point constants and command codes for the Maclaurin
// series evaluator and its channel interfaces.
// ----------------------------------------------------------------------------
package mse_pkg;

   // channel field widths
   localparam int CMD_W = 3;
   localparam int X_W   = 32;
   localparam int SUM_W = 64;
   localparam int CNT_W = 8;

   // fixed-point formats: argument Q3.28, sum and terms with FRAC_BITS fraction bits
   localparam int FRAC_BITS  = 32;
   localparam int XFRAC      = 28;
   localparam int UP_SHIFT   = (FRAC_BITS >= XFRAC) ? FRAC_BITS - XFRAC : 0;
   localparam int DOWN_SHIFT = (FRAC_BITS >= XFRAC) ? 0 : XFRAC - FRAC_BITS;

   // datapath widths
   localparam int MAG_W    = 63;
   localparam int MULT_W   = 64;
   localparam int LIMB_W   = 32;
   localparam int WIDE_W   = 128;
   localparam int DEN_W    = 18;
   localparam int QBITS    = 4;
   localparam int DIV_STEPS = WIDE_W / QBITS;
   localparam int STEP_W   = $clog2(DIV_STEPS);

   localparam logic [CNT_W-1:0] TERM_LIMIT_RESET = CNT_W'(64);

   // function select codes
   typedef enum logic [CMD_W-1:0] {
      CMD_EXP  = 3'd0,
      CMD_SIN  = 3'd1,
      CMD_COS  = 3'd2,
      CMD_SINH = 3'd3,
      CMD_COSH = 3'd4,
      CMD_ATAN = 3'd5
   } cmd_type;

endpackage

### src/mse_req_if.sv
// ----------------------------------------------------------------------------
// mse_req_if
// Request channel: function select and Q3.28 argument, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mse_req_if import mse_pkg::*; ();

   logic                    valid;
   logic                    ready;
   logic [CMD_W-1:0]        command;
   logic signed [X_W-1:0]   x_value;

   modport source (output valid, output command, output x_value, input ready);
   modport sink   (input valid, input command, input x_value, output ready);

endinterface

### src/mse_rsp_if.sv
// ----------------------------------------------------------------------------
// mse_rsp_if
// Response channel: series sum, status flags and term count, valid/ready.
// ----------------------------------------------------------------------------
interface mse_rsp_if import mse_pkg::*; ();

   logic                      valid;
   logic                      ready;
   logic signed [SUM_W-1:0]   result_value;
   logic                      not_converged;
   logic                      domain_error;
   logic [CNT_W-1:0]          terms_used;

   modport source (output valid, output result_value, output not_converged,
                   output domain_error, output terms_used, input ready);
   modport sink   (input valid, input result_value, input not_converged,
                   input domain_error, input terms_used, output ready);

endinterface

### src/maclaurin_series_evaluator.sv
// ----------------------------------------------------------------------------
// maclaurin_series_evaluator
// Evaluates exp, sin, cos, sinh, cosh or arctan of a Q3.28 argument by summing
// Maclaurin terms; each term comes from the last by the term ratio, computed
// on one shared 32x32 multiplier and a 4-bit-per-cycle restoring divider.
//
//   channel   dir   handshake             payload
//   req_ch    in    valid/ready           command, x_value
//   rsp_ch    out   valid/ready           result_value, not_converged,
//                                         domain_error, terms_used
//   csr       in    csr_wr_en             csr_wr_data (term limit)
//
// Each summed term passes the denominator, four partial products (four more for
// arctan), the restoring divide of the 128-bit product and the term update.
// A rejected argument or command goes to the output register without any term.
// Reset clears the sequencer and the result valid and sets the term limit to 64.
// req_ch.ready is high only while idle; a finished item waits in the output
// register and the next item is accepted meanwhile.
// ----------------------------------------------------------------------------
module maclaurin_series_evaluator import mse_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [CNT_W-1:0]  csr_wr_data,
   mse_req_if.sink           req_ch,
   mse_rsp_if.source         rsp_ch
);

   localparam logic [MAG_W-1:0] MAG_MAX = '1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_SETUP,
      ST_CHECK,
      ST_DENOM,
      ST_MUL,
      ST_NUMER,
      ST_DLOAD,
      ST_DIV,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   state_type                state_ff, state_in;
   cmd_type                  cmd_ff, cmd_in;
   logic                     xneg_ff, xneg_in;
   logic [X_W-1:0]           xmag_ff, xmag_in;
   logic [MULT_W-1:0]        mult_ff, mult_in;
   logic [MAG_W-1:0]         mag_ff, mag_in;
   logic                     neg_ff, neg_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         n_ff, n_in;
   logic                     nc_ff, nc_in;
   logic                     dom_ff, dom_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic [2*LIMB_W-1:0]      prod_ff, prod_in;
   logic [DEN_W-1:0]         denom_ff, denom_in;
   logic [WIDE_W-1:0]        acc_ff, acc_in;
   logic [WIDE_W-1:0]        num_ff, num_in;
   logic [WIDE_W-1:0]        div_ff, div_in;
   logic [DEN_W-1:0]         rem_ff, rem_in;
   logic [CNT_W-1:0]         limit_ff, limit_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [SUM_W-1:0]  rsp_result_ff, rsp_result_in;
   logic                     rsp_nc_ff, rsp_nc_in;
   logic                     rsp_dom_ff, rsp_dom_in;
   logic [CNT_W-1:0]         rsp_terms_ff, rsp_terms_in;

   // shared multiplier
   logic [LIMB_W-1:0]        mul_a, mul_b;
   logic [2*LIMB_W-1:0]      mul_p;

   // divider step results
   logic [WIDE_W-1:0]        div_q;
   logic [DEN_W-1:0]         div_r;
   logic [DEN_W:0]           trial;

   // misc combinational helpers
   logic [X_W-1:0]           req_xmag;
   logic                     req_xneg;
   logic                     req_bad;
   logic [SUM_W:0]           ext_sum;
   logic [CNT_W:0]           two_n;
   logic [WIDE_W-1:0]        dl_src;
   logic [1:0]               prev_k;

   // place a 64-bit partial product at limb offset k
   function automatic logic [WIDE_W-1:0] place_limbs(input logic [2*LIMB_W-1:0] p,
                                                     input logic [1:0] k);
      logic [WIDE_W-1:0] w;
      w = WIDE_W'(p);
      unique case (k)
         2'd0: place_limbs = w;
         2'd1: place_limbs = w << LIMB_W;
         2'd2: place_limbs = w << (2 * LIMB_W);
         2'd3: place_limbs = w << (3 * LIMB_W);
         default: place_limbs = w;
      endcase
   endfunction

   assign mul_p = (2*LIMB_W)'(mul_a) * (2*LIMB_W)'(mul_b);

   // restoring divide, QBITS quotient bits per cycle
   always_comb begin
      div_r = rem_ff;
      div_q = div_ff;
      trial = '0;
      for (int i = 0; i < QBITS; i++) begin
         trial = {div_r, div_q[WIDE_W-1]};
         div_q = {div_q[WIDE_W-2:0], 1'b0};
         if (trial >= {1'b0, denom_ff}) begin
            trial    = trial - {1'b0, denom_ff};
            div_q[0] = 1'b1;
         end
         div_r = trial[DEN_W-1:0];
      end
   end

   // argument decode at the request port
   assign req_xneg = req_ch.x_value[X_W-1];
   assign req_xmag = req_xneg ? (~req_ch.x_value + X_W'(1)) : req_ch.x_value;
   assign req_bad  = (req_ch.command > CMD_ATAN) ||
                     ((req_ch.command == CMD_ATAN) && (req_xmag > (X_W'(1) << XFRAC)));

   // saturating accumulate of the current term
   assign ext_sum = neg_ff ? ({sum_ff[SUM_W-1], sum_ff} - {2'b00, mag_ff})
                           : ({sum_ff[SUM_W-1], sum_ff} + {2'b00, mag_ff});

   assign two_n  = {n_ff, 1'b0};
   assign dl_src = (cmd_ff == CMD_ATAN) ? num_ff : acc_ff;
   assign prev_k = 2'(step_ff[1:0] - 2'd1);

   assign req_ch.ready = (state_ff == ST_IDLE);

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      xneg_in       = xneg_ff;
      xmag_in       = xmag_ff;
      mult_in       = mult_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      sum_in        = sum_ff;
      count_in      = count_ff;
      n_in          = n_ff;
      nc_in         = nc_ff;
      dom_in        = dom_ff;
      step_in       = step_ff;
      prod_in       = prod_ff;
      denom_in      = denom_ff;
      acc_in        = acc_ff;
      num_in        = num_ff;
      div_in        = div_ff;
      rem_in        = rem_ff;
      limit_in      = csr_wr_en ? csr_wr_data : limit_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_result_in = rsp_result_ff;
      rsp_nc_in     = rsp_nc_ff;
      rsp_dom_in    = rsp_dom_ff;
      rsp_terms_in  = rsp_terms_ff;
      mul_a         = '0;
      mul_b         = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               xneg_in  = req_xneg;
               xmag_in  = req_xmag;
               sum_in   = '0;
               count_in = '0;
               n_in     = '0;
               nc_in    = 1'b0;
               dom_in   = req_bad;
               if (req_bad) begin
                  state_in = ST_FINISH;
               end else begin
                  cmd_in = cmd_type'(req_ch.command);
                  if ((req_ch.command == CMD_EXP) || (req_ch.command == CMD_COS) ||
                      (req_ch.command == CMD_COSH)) begin
                     mag_in = MAG_W'(1) << FRAC_BITS;
                     neg_in = 1'b0;
                  end else begin
                     mag_in = (MAG_W'(req_xmag) << UP_SHIFT) >> DOWN_SHIFT;
                     neg_in = req_xneg;
                  end
                  state_in = ST_SQUARE;
               end
            end
         end

         // x squared for the odd/even series
         ST_SQUARE: begin
            mul_a    = xmag_ff;
            mul_b    = xmag_ff;
            prod_in  = mul_p;
            state_in = ST_SETUP;
         end

         ST_SETUP: begin
            mult_in  = (cmd_ff == CMD_EXP) ? MULT_W'(xmag_ff) : prod_ff;
            state_in = ST_CHECK;
         end

         // stop test, then add the term
         ST_CHECK: begin
            if (mag_ff == '0) begin
               state_in = ST_FINISH;
            end else if (count_ff >= limit_ff) begin
               nc_in    = 1'b1;
               state_in = ST_FINISH;
            end else begin
               if (ext_sum[SUM_W:SUM_W-1] == 2'b01) begin
                  sum_in = {1'b0, {(SUM_W-1){1'b1}}};
               end else if (ext_sum[SUM_W:SUM_W-1] == 2'b10) begin
                  sum_in = {1'b1, {(SUM_W-1){1'b0}}};
               end else begin
                  sum_in = ext_sum[SUM_W-1:0];
               end
               count_in = count_ff + CNT_W'(1);
               n_in     = n_ff + CNT_W'(1);
               state_in = ST_DENOM;
            end
         end

         // term ratio denominator
         ST_DENOM: begin
            unique case (cmd_ff)
               CMD_SIN, CMD_SINH: begin
                  mul_a = LIMB_W'(two_n);
                  mul_b = LIMB_W'(two_n) + LIMB_W'(1);
               end
               CMD_COS, CMD_COSH: begin
                  mul_a = LIMB_W'(two_n);
                  mul_b = LIMB_W'(two_n) - LIMB_W'(1);
               end
               CMD_ATAN: begin
                  mul_a = LIMB_W'(two_n) + LIMB_W'(1);
                  mul_b = LIMB_W'(1);
               end
               default: begin
                  mul_a = LIMB_W'(n_ff);
                  mul_b = LIMB_W'(1);
               end
            endcase
            prod_in  = mul_p;
            step_in  = '0;
            state_in = ST_MUL;
         end

         // term times multiplier, four partial products
         ST_MUL: begin
            if (step_ff == '0) begin
               denom_in = prod_ff[DEN_W-1:0];
               acc_in   = '0;
            end else begin
               acc_in = acc_ff + place_limbs(prod_ff, 2'(prev_k[1]) + 2'(prev_k[0]));
            end
            if (step_ff < STEP_W'(4)) begin
               mul_a   = step_ff[1] ? LIMB_W'(mag_ff[MAG_W-1:LIMB_W]) : mag_ff[LIMB_W-1:0];
               mul_b   = step_ff[0] ? mult_ff[MULT_W-1:LIMB_W] : mult_ff[LIMB_W-1:0];
               prod_in = mul_p;
               step_in = step_ff + STEP_W'(1);
            end else begin
               step_in  = '0;
               state_in = (cmd_ff == CMD_ATAN) ? ST_NUMER : ST_DLOAD;
            end
         end

         // arctan: product times (2n-1), limb by limb
         ST_NUMER: begin
            if (step_ff == '0) begin
               num_in = '0;
            end else begin
               num_in = num_ff + place_limbs(prod_ff, prev_k);
            end
            if (step_ff < STEP_W'(4)) begin
               unique case (step_ff[1:0])
                  2'd0: mul_a = acc_ff[LIMB_W-1:0];
                  2'd1: mul_a = acc_ff[2*LIMB_W-1:LIMB_W];
                  2'd2: mul_a = acc_ff[3*LIMB_W-1:2*LIMB_W];
                  2'd3: mul_a = acc_ff[4*LIMB_W-1:3*LIMB_W];
                  default: mul_a = '0;
               endcase
               mul_b   = LIMB_W'(two_n) - LIMB_W'(1);
               prod_in = mul_p;
               step_in = step_ff + STEP_W'(1);
            end else begin
               step_in  = '0;
               state_in = ST_DLOAD;
            end
         end

         ST_DLOAD: begin
            div_in   = (cmd_ff == CMD_EXP) ? (dl_src >> XFRAC) : (dl_src >> (2 * XFRAC));
            rem_in   = '0;
            step_in  = '0;
            state_in = ST_DIV;
         end

         ST_DIV: begin
            div_in  = div_q;
            rem_in  = div_r;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = ST_UPDATE;
            end
         end

         // clamp the new term and set its sign
         ST_UPDATE: begin
            mag_in = (div_ff[WIDE_W-1:MAG_W] != '0) ? MAG_MAX : div_ff[MAG_W-1:0];
            unique case (cmd_ff)
               CMD_EXP:             neg_in = neg_ff ^ xneg_ff;
               CMD_SINH, CMD_COSH:  neg_in = neg_ff;
               default:             neg_in = ~neg_ff;
            endcase
            state_in = ST_CHECK;
         end

         // hand the item to the output register
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_result_in = sum_ff;
               rsp_nc_in     = nc_ff;
               rsp_dom_in    = dom_ff;
               rsp_terms_in  = count_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= TERM_LIMIT_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         limit_ff     <= limit_in;
      end
      cmd_ff        <= cmd_in;
      xneg_ff       <= xneg_in;
      xmag_ff       <= xmag_in;
      mult_ff       <= mult_in;
      mag_ff        <= mag_in;
      neg_ff        <= neg_in;
      sum_ff        <= sum_in;
      count_ff      <= count_in;
      n_ff          <= n_in;
      nc_ff         <= nc_in;
      dom_ff        <= dom_in;
      step_ff       <= step_in;
      prod_ff       <= prod_in;
      denom_ff      <= denom_in;
      acc_ff        <= acc_in;
      num_ff        <= num_in;
      div_ff        <= div_in;
      rem_ff        <= rem_in;
      rsp_result_ff <= rsp_result_in;
      rsp_nc_ff     <= rsp_nc_in;
      rsp_dom_ff    <= rsp_dom_in;
      rsp_terms_ff  <= rsp_terms_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.result_value  = rsp_result_ff;
   assign rsp_ch.not_converged = rsp_nc_ff;
   assign rsp_ch.domain_error  = rsp_dom_ff;
   assign rsp_ch.terms_used    = rsp_terms_ff;

endmodule

### tb/maclaurin_series_evaluator_tb.sv
// ----------------------------------------------------------------------------
// maclaurin_series_evaluator_tb
// Drives function commands and Q3.28 arguments into the series evaluator and
// checks each returned sum, flag and term count against a predictor. The
// predictor runs the same term-ratio recurrence at full width. Directed edge
// arguments and term limits come first, then random traffic under three idle
// profiles on the request and response sides.
// ----------------------------------------------------------------------------
module maclaurin_series_evaluator_tb import mse_pkg::*; ();

   // codes that the package leaves unnamed
   localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

   // argument edges, Q3.28
   localparam logic [X_W-1:0] ONE_Q28 = 32'h1000_0000;
   localparam logic [X_W-1:0] X_MAX   = 32'h7FFF_FFFF;
   localparam logic [X_W-1:0] X_MIN   = 32'h8000_0000;

   localparam logic [63:0] MAG_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam longint SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint SUM_MIN = 64'sh8000_0000_0000_0000;

   localparam int STALL_LIMIT   = 50000;
   localparam int SETTLE_CYCLES = 8;
   localparam int FINAL_CYCLES  = 50;

   typedef struct packed {
      logic signed [SUM_W-1:0] result_value;
      logic                    not_converged;
      logic                    domain_error;
      logic [CNT_W-1:0]        terms_used;
   } series_result_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_wr_en;
   logic [CNT_W-1:0] csr_wr_data;

   mse_req_if req_ch ();
   mse_rsp_if rsp_ch ();

   maclaurin_series_evaluator u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

   series_result_type pending_series[$];
   logic [CNT_W-1:0]  limit_model;
   logic [CNT_W-1:0]  spot_limit;
   int                sender_idle_pct;
   int                recv_idle_pct;
   int                mismatch_count   = 0;
   int                items_accepted   = 0;
   int                results_checked  = 0;
   int                domain_seen      = 0;
   int                unconverged_seen = 0;
   int                quiet_cycles     = 0;

   always #5 clock = ~clock;

   // one step of the term-ratio recurrence on a magnitude
   function automatic logic [63:0] next_term(input logic [63:0] mag, input logic [63:0] mult,
                                             input logic [63:0] numer, input int shift,
                                             input logic [63:0] denom);
      logic [127:0] w;
      w = 128'(mag) * 128'(mult);
      w = w * 128'(numer);
      w = w >> shift;
      w = w / 128'(denom);
      return (|w[127:63]) ? MAG_LIMIT : w[63:0];
   endfunction

   function automatic longint add_saturated(input longint acc, input logic [63:0] mag,
                                            input logic neg);
      longint m;
      m = longint'(mag);
      if (neg)
         return (acc < SUM_MIN + m) ? SUM_MIN : acc - m;
      return (acc > SUM_MAX - m) ? SUM_MAX : acc + m;
   endfunction

   // full series evaluation for one item
   function automatic series_result_type evaluate_series(input logic [CMD_W-1:0] cmd,
                                                         input logic [X_W-1:0] x,
                                                         input logic [CNT_W-1:0] limit);
      logic          xneg;
      logic [31:0]   xmag;
      logic [63:0]   x_sq;
      logic [63:0]   mag;
      logic          neg;
      longint        acc;
      logic [63:0]   k;
      bit            done;
      series_result_type r;
      xneg = x[X_W-1];
      xmag = xneg ? (~x + 32'd1) : x;
      x_sq = 64'(xmag) * 64'(xmag);
      r = '0;
      // unused codes and arctan beyond one
      if (cmd > CMD_ATAN || (cmd == CMD_ATAN && xmag > ONE_Q28)) begin
         r.domain_error = 1'b1;
         return r;
      end
      if (cmd == CMD_EXP || cmd == CMD_COS || cmd == CMD_COSH) begin
         mag = 64'd1 << FRAC_BITS;
         neg = 1'b0;
      end else begin
         mag = (64'(xmag) << UP_SHIFT) >> DOWN_SHIFT;
         neg = xneg;
      end
      acc  = 0;
      k    = 64'd0;
      done = 1'b0;
      while (!done) begin
         if (mag == 0) begin
            done = 1'b1;
         end else if (r.terms_used >= limit) begin
            r.not_converged = 1'b1;
            done = 1'b1;
         end else begin
            acc = add_saturated(acc, mag, neg);
            r.terms_used = r.terms_used + CNT_W'(1);
            k = k + 64'd1;
            case (cmd)
               CMD_EXP: begin
                  mag = next_term(mag, 64'(xmag), 64'd1, XFRAC, k);
                  neg = neg ^ xneg;
               end
               CMD_SIN, CMD_SINH: begin
                  mag = next_term(mag, x_sq, 64'd1, 2 * XFRAC, (2 * k) * (2 * k + 1));
                  if (cmd == CMD_SIN) neg = !neg;
               end
               CMD_COS, CMD_COSH: begin
                  mag = next_term(mag, x_sq, 64'd1, 2 * XFRAC, (2 * k) * (2 * k - 1));
                  if (cmd == CMD_COS) neg = !neg;
               end
               default: begin
                  mag = next_term(mag, x_sq, 2 * k - 1, 2 * XFRAC, 2 * k + 1);
                  neg = !neg;
               end
            endcase
         end
      end
      r.result_value = acc;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch on %s at result %0d: got %h, expected %h",
               what, results_checked, got, want);
      mismatch_count++;
   endtask

   // drive one item, with random idle cycles ahead of it
   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [X_W-1:0] x);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.command <= cmd;
      req_ch.x_value <= x;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // stop sending and wait for every outstanding sum
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (pending_series.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_term_limit(input logic [CNT_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      limit_model = value;
      @(negedge clock);
   endtask

   // zero, both ends of the range, arctan around one, unused codes
   task automatic test_edge_arguments();
      send_item(CMD_EXP, '0);
      send_item(CMD_SIN, '0);
      for (int c = CMD_EXP; c <= CMD_COSH; c++) begin
         send_item(CMD_W'(c), X_MAX);
         send_item(CMD_W'(c), X_MIN);
      end
      send_item(CMD_ATAN, '0);
      send_item(CMD_ATAN, ONE_Q28);
      send_item(CMD_ATAN, -ONE_Q28);
      send_item(CMD_ATAN, ONE_Q28 + 32'd1);
      send_item(CMD_ATAN, X_MIN);
      send_item(CMD_SPARE6, ONE_Q28 >> 1);
      send_item(CMD_SPARE7, '0);
      drain_results();
   endtask

   // zero, one and the largest term limit
   task automatic test_term_limits();
      write_term_limit(8'd0);
      send_item(CMD_EXP, ONE_Q28);
      send_item(CMD_SIN, '0);
      send_item(CMD_ATAN, 2 * ONE_Q28);
      drain_results();
      write_term_limit(8'd1);
      send_item(CMD_COSH, -(3 * ONE_Q28));
      send_item(CMD_ATAN, ONE_Q28 >> 1);
      drain_results();
      write_term_limit(8'd255);
      send_item(CMD_EXP, X_MIN);
      send_item(CMD_ATAN, -ONE_Q28);
      drain_results();
   endtask

   // random commands and arguments, mostly inside the useful range
   task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct,
                                      input logic [CNT_W-1:0] limit);
      logic [CMD_W-1:0] cmd;
      logic [X_W-1:0]   x;
      write_term_limit(limit);
      sender_idle_pct = send_pct;
      recv_idle_pct   = recv_pct;
      for (int i = 0; i < count; i++) begin
         // hold off once until the block has answered everything
         if (i == count / 2) drain_results();
         if ($urandom_range(15) == 0)
            cmd = CMD_W'($urandom_range(CMD_SPARE7));
         else
            cmd = CMD_W'($urandom_range(CMD_ATAN));
         case ($urandom_range(9))
            0, 1, 2, 3: x = $urandom_range(ONE_Q28);
            4, 5, 6:    x = $urandom_range(4 * ONE_Q28);
            7, 8:       x = $urandom();
            default: begin
               case ($urandom_range(4))
                  0:       x = '0;
                  1:       x = 32'd1;
                  2:       x = ONE_Q28;
                  3:       x = ONE_Q28 + 32'd1;
                  default: x = X_MAX;
               endcase
            end
         endcase
         if ($urandom_range(1)) x = -x;
         send_item(cmd, x);
      end
      drain_results();
   endtask

   // result ready with random stalls
   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // predict each accepted item
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         pending_series.push_back(evaluate_series(req_ch.command, req_ch.x_value,
                                                  limit_model));
         items_accepted++;
      end
   end

   // compare each accepted result with the oldest prediction
   always @(posedge clock) begin
      series_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_series.size() == 0) begin
            report_mismatch("unexpected result", rsp_ch.result_value, '0);
         end else begin
            want = pending_series.pop_front();
            if (rsp_ch.result_value !== want.result_value)
               report_mismatch("result_value", rsp_ch.result_value, want.result_value);
            if (rsp_ch.not_converged !== want.not_converged)
               report_mismatch("not_converged", rsp_ch.not_converged, want.not_converged);
            if (rsp_ch.domain_error !== want.domain_error)
               report_mismatch("domain_error", rsp_ch.domain_error, want.domain_error);
            if (rsp_ch.terms_used !== want.terms_used)
               report_mismatch("terms_used", rsp_ch.terms_used, want.terms_used);
            if (want.domain_error) domain_seen++;
            if (want.not_converged) unconverged_seen++;
            results_checked++;
         end
      end
   end

   // end the run when no item moves for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      req_ch.valid   = 1'b0;
      req_ch.command = '0;
      req_ch.x_value = '0;
      rsp_ch.ready   = 1'b0;
      limit_model    = TERM_LIMIT_RESET;
      sender_idle_pct = 11;
      recv_idle_pct   = 56;
      spot_limit     = CNT_W'($urandom_range(40, 8));
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_edge_arguments();
      test_term_limits();
      test_random_traffic(88, 11, 56, TERM_LIMIT_RESET);
      test_random_traffic(88, 56, 11, spot_limit);
      test_random_traffic(88, 0, 0, 8'd255);

      repeat (FINAL_CYCLES) @(negedge clock);
      if (pending_series.size() != 0)
         report_mismatch("missing results", pending_series.size(), '0);

      $display("run: %0d items sent, %0d results checked, %0d domain errors, %0d unconverged",
               items_accepted, results_checked, domain_seen, unconverged_seen);
      $display("run: six functions and unused codes, term limits 0, 1, 64, %0d and 255",
               spot_limit);
      if (mismatch_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

### sim.f
src/mse_pkg.sv
src/mse_req_if.sv
src/mse_rsp_if.sv
src/maclaurin_series_evaluator.sv
tb/maclaurin_series_evaluator_tb.sv
